>>> design/journal_slot_recovery_table_macros.svh
// Assertion macros shared by the journal slot recovery table.
`ifndef JOURNAL_SLOT_RECOVERY_TABLE_MACROS_SVH
`define JOURNAL_SLOT_RECOVERY_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define JSRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define JSRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSRT_ASSERT_NOW(lbl, ante, cons, msg)
`define JSRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/jsrt_pkg.sv
// Types, codes and constants of the journal slot recovery table.
package jsrt_pkg;

  // Field widths fixed by the interface.
  localparam int NODE_W      = 16;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int SLOT_IDX_W  = 5;
  localparam int SLOTS_W     = 6;
  localparam int STATE_W     = 2;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;

  // Default table depth.
  localparam int DEF_MAX_SLOTS = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLAIM   = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK    = 3'd2;
  localparam logic [OP_W-1:0] OP_BEGIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

  // Slot states.
  localparam logic [STATE_W-1:0] ST_FREE       = 2'd0;
  localparam logic [STATE_W-1:0] ST_ACTIVE     = 2'd1;
  localparam logic [STATE_W-1:0] ST_NEEDS      = 2'd2;
  localparam logic [STATE_W-1:0] ST_RECOVERING = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] RES_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] RES_NOMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] RES_BUSY    = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_NODE_ID = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOTS_IN_USE  = 1'd1;
  localparam logic [NODE_W-1:0]     LOCAL_NODE_RST    = 16'd1;
  localparam logic [SLOTS_W-1:0]    SLOTS_IN_USE_RST  = 6'd32;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_id;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  needs_recovery_flag;
    logic [NODE_W-1:0]     busy_recoverer;
  } out_item_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [NODE_W-1:0]  owner;
    logic [NODE_W-1:0]  recoverer;
  } slot_word_t;

  localparam int SLOT_WORD_W = $bits(slot_word_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/jsrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/jsrt_ctrl.sv
// Controller state machine that sequences accept, scan and commit.
module jsrt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  jsrt_pkg::dp_status_t  status,
  output jsrt_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Commands are decoded combinationally from the state, in_valid and out_free.
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = in_valid && (state_r == S_IDLE);
  assign cmd.step   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && status.out_free;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/jsrt_dp.sv
// Datapath: configuration, slot memory, serial scan, commit and result register.
module jsrt_dp #(
  parameter int MAX_SLOTS = jsrt_pkg::DEF_MAX_SLOTS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [jsrt_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [jsrt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  jsrt_pkg::in_item_t                     in_item,
  input  jsrt_pkg::ctrl_cmd_t                    cmd,
  output jsrt_pkg::dp_status_t                   status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output jsrt_pkg::out_item_t                    out_item
);

  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int LIM_W     = (CNT_W > jsrt_pkg::SLOTS_W) ? CNT_W : jsrt_pkg::SLOTS_W;
  localparam int OUT_IDX_W = jsrt_pkg::SLOT_IDX_W;
  localparam int WORD_W    = jsrt_pkg::SLOT_WORD_W;
  localparam int STATE_W_LOCAL = jsrt_pkg::STATE_W;

  // Configuration registers.
  logic [jsrt_pkg::NODE_W-1:0]  local_id_r;
  logic [jsrt_pkg::SLOTS_W-1:0] slots_r;

  // Item being worked on.
  logic [jsrt_pkg::OP_W-1:0]    op_r;
  logic [jsrt_pkg::NODE_W-1:0]  node_r;

  // Scan state.
  logic [CNT_W-1:0]             addr_r;
  logic                         chk_v_r;
  logic [IDX_W-1:0]             chk_idx_r;
  logic                         chk_vld_r;

  // Search results.
  logic                         hit_r;
  logic [IDX_W-1:0]             hit_idx_r;
  jsrt_pkg::slot_word_t         hit_word_r;
  logic                         busy_r;
  logic [IDX_W-1:0]             busy_idx_r;
  logic [jsrt_pkg::NODE_W-1:0]  busy_rec_r;

  // Held slot and per-entry valid bits; an entry that is not valid is free.
  logic [IDX_W-1:0]             own_r;
  logic                         own_v_r;
  logic [MAX_SLOTS-1:0]         valid_r;

  // Result register.
  logic                         out_valid_r;
  jsrt_pkg::out_item_t          out_item_r;

  // Memory ports.
  logic [WORD_W-1:0]            ram_rd_data;
  jsrt_pkg::slot_word_t         rd_word;
  logic                         wr_req;
  logic [WORD_W-1:0]            wr_data;
  logic                         set_req;
  logic                         clr_req;
  logic [IDX_W-1:0]             clr_addr;
  logic                         take_own;
  logic                         drop_own;
  jsrt_pkg::out_item_t          res_nxt;

  // Scan control.
  logic [LIM_W-1:0]             lim;
  logic [STATE_W_LOCAL-1:0]     cur_state;
  logic                         own_match;
  logic                         scan_op;
  logic                         hit_now;
  logic                         busy_now;
  logic                         more;
  logic                         issue;
  logic [IDX_W-1:0]             addr_idx;

  jsrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && wr_req),
    .wr_addr (hit_idx_r),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (addr_idx),
    .rd_data (ram_rd_data)
  );

  // Searched range is the configured count, limited to the table depth.
  always_comb begin
    if (LIM_W'(slots_r) > LIM_W'(MAX_SLOTS)) begin
      lim = LIM_W'(MAX_SLOTS);
    end else begin
      lim = LIM_W'(slots_r);
    end
  end

  assign addr_idx = addr_r[IDX_W-1:0];
  assign more     = (LIM_W'(addr_r) < lim);
  assign issue    = cmd.step && more;

  // Compare stage on the entry read in the previous cycle.
  assign rd_word   = jsrt_pkg::slot_word_t'(ram_rd_data);
  assign cur_state = chk_vld_r ? rd_word.state : jsrt_pkg::ST_FREE;
  assign own_match = (rd_word.owner == node_r);

  always_comb begin
    scan_op = 1'b0;
    hit_now = 1'b0;
    case (op_r)
      jsrt_pkg::OP_CLAIM: begin
        scan_op = !own_v_r;
        hit_now = !own_v_r && (cur_state == jsrt_pkg::ST_FREE);
      end
      jsrt_pkg::OP_MARK: begin
        scan_op = 1'b1;
        hit_now = own_match && (cur_state == jsrt_pkg::ST_ACTIVE);
      end
      jsrt_pkg::OP_BEGIN, jsrt_pkg::OP_QUERY: begin
        scan_op = 1'b1;
        hit_now = own_match && (cur_state == jsrt_pkg::ST_NEEDS);
      end
      jsrt_pkg::OP_FINISH: begin
        scan_op = 1'b1;
        hit_now = own_match && (cur_state == jsrt_pkg::ST_RECOVERING);
      end
      default: begin
        scan_op = 1'b0;
        hit_now = 1'b0;
      end
    endcase
    hit_now = hit_now && chk_v_r;
  end

  // Begin also remembers the first slot already being recovered.
  assign busy_now = chk_v_r && !busy_r && (op_r == jsrt_pkg::OP_BEGIN) && own_match &&
                    (cur_state == jsrt_pkg::ST_RECOVERING);

  assign status.scan_done = !scan_op || hit_now || !more;
  assign status.out_free  = !out_valid_r || out_ready;

  // Commit decisions: table update and result item.
  always_comb begin
    jsrt_pkg::slot_word_t w;
    w        = hit_word_r;
    wr_req   = 1'b0;
    set_req  = 1'b0;
    clr_req  = 1'b0;
    clr_addr = hit_idx_r;
    take_own = 1'b0;
    drop_own = 1'b0;
    res_nxt  = '0;
    case (op_r)
      jsrt_pkg::OP_CLAIM: begin
        if (own_v_r) begin
          res_nxt.slot_index = OUT_IDX_W'(own_r);
        end else if (hit_r) begin
          w.state  = jsrt_pkg::ST_ACTIVE;
          w.owner  = local_id_r;
          wr_req   = 1'b1;
          set_req  = 1'b1;
          take_own = 1'b1;
          res_nxt.slot_index = OUT_IDX_W'(hit_idx_r);
        end else begin
          res_nxt.status = jsrt_pkg::RES_NOSPACE;
        end
      end
      jsrt_pkg::OP_RELEASE: begin
        drop_own = 1'b1;
        if (own_v_r) begin
          clr_req  = 1'b1;
          clr_addr = own_r;
          res_nxt.slot_index = OUT_IDX_W'(own_r);
        end
      end
      jsrt_pkg::OP_MARK: begin
        if (hit_r) begin
          w.state = jsrt_pkg::ST_NEEDS;
          wr_req  = 1'b1;
          res_nxt.slot_index = OUT_IDX_W'(hit_idx_r);
        end else begin
          res_nxt.status = jsrt_pkg::RES_NOMATCH;
        end
      end
      jsrt_pkg::OP_BEGIN: begin
        if (hit_r) begin
          w.state     = jsrt_pkg::ST_RECOVERING;
          w.recoverer = local_id_r;
          wr_req      = 1'b1;
          res_nxt.slot_index = OUT_IDX_W'(hit_idx_r);
        end else if (busy_r) begin
          res_nxt.status         = jsrt_pkg::RES_BUSY;
          res_nxt.slot_index     = OUT_IDX_W'(busy_idx_r);
          res_nxt.busy_recoverer = busy_rec_r;
        end else begin
          res_nxt.status = jsrt_pkg::RES_NOMATCH;
        end
      end
      jsrt_pkg::OP_FINISH: begin
        if (hit_r) begin
          clr_req = 1'b1;
          res_nxt.slot_index = OUT_IDX_W'(hit_idx_r);
        end else begin
          res_nxt.status = jsrt_pkg::RES_NOMATCH;
        end
      end
      jsrt_pkg::OP_QUERY: begin
        if (hit_r) begin
          res_nxt.needs_recovery_flag = 1'b1;
          res_nxt.slot_index          = OUT_IDX_W'(hit_idx_r);
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    wr_data = WORD_W'(w);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_id_r <= jsrt_pkg::LOCAL_NODE_RST;
      slots_r    <= jsrt_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jsrt_pkg::REG_LOCAL_NODE_ID: local_id_r <= cfg_wdata;
        jsrt_pkg::REG_SLOTS_IN_USE:  slots_r    <= cfg_wdata[jsrt_pkg::SLOTS_W-1:0];
        default: begin
          local_id_r <= local_id_r;
        end
      endcase
    end
  end

  // Item capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
      hit_r   <= 1'b0;
      busy_r  <= 1'b0;
      addr_r  <= '0;
    end else if (cmd.start) begin
      op_r    <= in_item.op;
      node_r  <= in_item.node_id;
      addr_r  <= '0;
      chk_v_r <= 1'b0;
      hit_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else if (cmd.step) begin
      chk_v_r <= issue;
      if (issue) begin
        addr_r    <= addr_r + 1'b1;
        chk_idx_r <= addr_idx;
        chk_vld_r <= valid_r[addr_idx];
      end
      if (hit_now) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= chk_idx_r;
        hit_word_r <= rd_word;
      end
      if (busy_now) begin
        busy_r     <= 1'b1;
        busy_idx_r <= chk_idx_r;
        busy_rec_r <= rd_word.recoverer;
      end
    end
  end

  // Held slot and valid bits change only at commit or reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= '0;
      own_v_r <= 1'b0;
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (set_req) begin
        valid_r[hit_idx_r] <= 1'b1;
      end
      if (clr_req) begin
        valid_r[clr_addr] <= 1'b0;
      end
      if (take_own) begin
        own_r   <= hit_idx_r;
        own_v_r <= 1'b1;
      end
      if (drop_own) begin
        own_r   <= '0;
        own_v_r <= 1'b0;
      end
    end
  end

  // Result register; a waiting result is held until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/journal_slot_recovery_table.sv
// Top level of the journal slot recovery table.
// Usage: items (op, node_id) arrive on the in_ valid/ready channel and each
// one yields exactly one result (status, slot_index, needs_recovery_flag,
// busy_recoverer) on the out_ valid/ready channel. The cfg_ port writes
// local_node_id (index 0) and slots_in_use (index 1) at any edge with
// cfg_we high; write it only while no item is in flight.
// One item is worked on at a time. After a transfer the controller scans the
// slot memory one entry per cycle, up to min(slots_in_use, MAX_SLOTS) entries,
// stopping at the first match, then commits. The slot memory has a single read
// port and registered read data. The result sits in an output register, so the
// next item is accepted while the receiver stalls; its commit then waits until
// the register is free.
// A synchronous reset (rst_n low) frees every slot at once through per-slot
// valid bits, drops the held slot and restores the register defaults.
`include "journal_slot_recovery_table_macros.svh"
module journal_slot_recovery_table #(
  parameter int MAX_SLOTS = jsrt_pkg::DEF_MAX_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  jsrt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output jsrt_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [jsrt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [jsrt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  jsrt_pkg::ctrl_cmd_t  cmd;
  jsrt_pkg::dp_status_t status;

  jsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  jsrt_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  // Checks on the controller and result register working together.
  `JSRT_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid, "commit without result")
  `JSRT_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !cmd.commit, "result overwritten")
  `JSRT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken early")
  `JSRT_ASSERT_NOW(a_start_commit_apart, cmd.start, !cmd.commit && !cmd.step, "command clash")

endmodule
